[rtl/kenv_pkg.sv]
// Shared types and constants for the keyframe envelope interpolator.
// Holds transaction payload structs, request and status codes, the controller
// state type and the command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kenv_pkg;

    localparam int MAX_STAGES_DEF = 8;

    localparam int REQ_W    = 2;
    localparam int DUR_W    = 16;
    localparam int VAL_W    = 16;
    // Total of up to sixteen 16-bit durations fits in this width.
    localparam int TIME_W   = 20;
    localparam int STAGE_W  = 3;
    localparam int STATUS_W = 3;

    // Product of a 17-bit signed difference and a 17-bit signed fraction.
    localparam int PROD_W    = 2 * (VAL_W + 1);
    localparam int DIV_STEPS = DUR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;

    localparam logic [STATUS_W-1:0] STAT_EVALUATED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_APPENDED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_CLEARED   = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [DUR_W-1:0]        stage_duration_ms;
        logic signed [VAL_W-1:0] stage_value;
        logic [TIME_W-1:0]       sim_time_ms;
    } kenv_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [STAGE_W-1:0]      active_stage;
        logic [STATUS_W-1:0]     status;
        logic                    past_end;
    } kenv_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PREV,
        S_DIV,
        S_MUL,
        S_ADD,
        S_FINISH
    } kenv_state_t;

    typedef struct packed {
        logic accept;
        logic walk;
        logic prev;
        logic div;
        logic mul;
        logic add;
        logic publish;
    } kenv_cmd_t;

    typedef struct packed {
        logic eval_go;
        logic walk_end;
        logic walk_interp;
        logic at_end;
    } kenv_sts_t;

endpackage

`default_nettype wire

[rtl/kenv_datapath.sv]
// Datapath: stage table, cumulative-duration walk, restoring divider,
// multiplier and output register. Depends on kenv_pkg; driven by kenv_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module kenv_datapath #(
    parameter int MAX_STAGES = kenv_pkg::MAX_STAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kenv_pkg::kenv_in_t  in_data,
    input  kenv_pkg::kenv_cmd_t cmd,
    output kenv_pkg::kenv_sts_t sts,
    output kenv_pkg::kenv_out_t out_data
);
    import kenv_pkg::*;

    localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CNT_W = $clog2(MAX_STAGES + 1);

    logic [DUR_W-1:0]        stage_dur_reg [MAX_STAGES];
    logic signed [VAL_W-1:0] stage_val_reg [MAX_STAGES];
    logic [CNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [TIME_W-1:0]       time_reg;
    logic [TIME_W-1:0]       end_reg;
    logic [TIME_W-1:0]       start_reg;
    logic [DUR_W-1:0]        dur_reg;
    logic [DUR_W-1:0]        rem_reg;
    logic [DUR_W-1:0]        quo_reg;
    logic signed [VAL_W-1:0] cur_reg;
    logic signed [VAL_W-1:0] prev_reg;
    logic signed [PROD_W-1:0] prod_reg;
    kenv_out_t               res_reg;
    kenv_out_t               out_reg;

    logic [DUR_W-1:0]        rd_dur;
    logic signed [VAL_W-1:0] rd_val;
    logic [TIME_W-1:0]       end_next;
    logic                    hit;
    logic                    last;
    logic                    idx_zero;
    logic                    full;
    logic                    is_eval;
    logic [TIME_W-1:0]       num;
    logic [DUR_W:0]          rem_sh;
    logic [DUR_W:0]          rem_sub;
    logic                    rem_fit;
    logic signed [VAL_W:0]   diff;
    logic signed [DUR_W:0]   frac_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [VAL_W-1:0] interp;

    always_comb begin
        rd_dur   = stage_dur_reg[idx_reg];
        rd_val   = stage_val_reg[idx_reg];
        end_next = end_reg + TIME_W'(rd_dur);
        hit      = (time_reg <= end_next);
        last     = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));
        idx_zero = (idx_reg == '0);
        full     = (count_reg == CNT_W'(MAX_STAGES));
        is_eval  = (in_data.req_type != REQ_CLEAR) && (in_data.req_type != REQ_APPEND);
        num      = time_reg - start_reg;
        rem_sh   = {rem_reg, 1'b0};
        rem_sub  = rem_sh - {1'b0, dur_reg};
        rem_fit  = (rem_sh >= {1'b0, dur_reg});
        diff     = {cur_reg[VAL_W-1], cur_reg} - {prev_reg[VAL_W-1], prev_reg};
        frac_s   = $signed({1'b0, quo_reg});
        prod     = PROD_W'(diff) * PROD_W'(frac_s);
        // Arithmetic shift by the fraction width floors toward minus infinity.
        interp   = prev_reg + $signed(prod_reg[VAL_W+DUR_W-1:DUR_W]);

        sts.eval_go     = is_eval && (count_reg != '0);
        sts.walk_end    = (hit && idx_zero) || (!hit && last);
        sts.walk_interp = hit && !idx_zero;
        sts.at_end      = (num >= TIME_W'(dur_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.accept) begin
            if (in_data.req_type == REQ_CLEAR) begin
                count_reg <= '0;
            end else if (in_data.req_type == REQ_APPEND && !full) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            time_reg <= in_data.sim_time_ms;
            end_reg  <= '0;
            idx_reg  <= '0;
            res_reg.result_value <= '0;
            res_reg.active_stage <= '0;
            res_reg.past_end     <= 1'b0;
            priority if (in_data.req_type == REQ_CLEAR) begin
                res_reg.status <= STAT_CLEARED;
            end else if (in_data.req_type == REQ_APPEND) begin
                if (full) begin
                    res_reg.status <= STAT_DROPPED;
                end else begin
                    stage_dur_reg[count_reg[IDX_W-1:0]] <= in_data.stage_duration_ms;
                    stage_val_reg[count_reg[IDX_W-1:0]] <= in_data.stage_value;
                    res_reg.status <= STAT_APPENDED;
                end
            end else if (count_reg == '0) begin
                res_reg.status <= STAT_EMPTY;
            end else begin
                res_reg.status <= STAT_EVALUATED;
            end
        end

        if (cmd.walk) begin
            end_reg   <= end_next;
            start_reg <= end_reg;
            dur_reg   <= rd_dur;
            cur_reg   <= rd_val;
            res_reg.active_stage <= STAGE_W'(idx_reg);
            if ((hit && idx_zero) || (!hit && last)) begin
                res_reg.result_value <= rd_val;
            end
            if (!hit && last) begin
                res_reg.past_end <= 1'b1;
            end
            // Step back to read the previous stage value, or forward to the next stage.
            if (hit && !idx_zero) begin
                idx_reg <= idx_reg - IDX_W'(1);
            end else if (!hit && !last) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end

        if (cmd.prev) begin
            prev_reg <= rd_val;
            rem_reg  <= num[DUR_W-1:0];
            quo_reg  <= '0;
            if (sts.at_end) begin
                res_reg.result_value <= cur_reg;
            end
        end

        if (cmd.div) begin
            rem_reg <= rem_fit ? rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
            quo_reg <= {quo_reg[DUR_W-2:0], rem_fit};
        end

        if (cmd.mul) begin
            prod_reg <= prod;
        end

        if (cmd.add) begin
            res_reg.result_value <= interp;
        end

        if (cmd.publish) begin
            out_reg <= res_reg;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

[rtl/kenv_ctrl.sv]
// Controller state machine: sequences accept, table walk, divide, multiply
// and result hand-off. Depends on kenv_pkg; commands kenv_datapath.
`timescale 1ns / 1ps
`default_nettype none

module kenv_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  kenv_pkg::kenv_sts_t sts,
    output kenv_pkg::kenv_cmd_t cmd
);
    import kenv_pkg::*;

    kenv_state_t          state_reg;
    kenv_state_t          state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.eval_go ? S_WALK : S_FINISH;
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (sts.walk_end) begin
                    state_next = S_FINISH;
                end else if (sts.walk_interp) begin
                    state_next = S_PREV;
                end
            end
            S_PREV: begin
                cmd.prev   = 1'b1;
                cnt_next   = '0;
                state_next = sts.at_end ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/keyframe_envelope_interpolator.sv]
// Keyframe envelope interpolator: clear, append and evaluate transactions on a stage table.
// Clear, append and empty evaluate go straight to the output register; an evaluate walks
// the table (up to MAX_STAGES stages) until stage 0 or past-end decides, the fraction
// reaches one, or the 16-step serial divide, multiply and add have run.
// One transaction at a time: a new input is accepted only once the block is back in idle.
// Reset: aresetn synchronous active low empties the table and drops any output.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_envelope_interpolator #(
    parameter int MAX_STAGES = kenv_pkg::MAX_STAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kenv_pkg::kenv_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output kenv_pkg::kenv_out_t m_data
);
    import kenv_pkg::*;

    // Command and status between the sequencer and the datapath.
    kenv_cmd_t cmd;
    kenv_sts_t sts;

    // Sequencer: accept in idle, walk one stage per cycle, then divide
    // one quotient bit per cycle, multiply, add, and hand off the result.
    // The output register is free again once its transaction is taken, so a
    // new input is accepted while the previous result still waits.
    kenv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: stage table, running end time, restoring divider for the
    // Q0.16 fraction, 17x17 multiplier, and the output register.
    kenv_datapath #(
        .MAX_STAGES (MAX_STAGES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_data)
    );

endmodule

`default_nettype wire

[rtl/kenv_checker.sv]
// Port-level checker for keyframe_envelope_interpolator, attached by bind.
// Depends on kenv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kenv_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  kenv_pkg::kenv_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  kenv_pkg::kenv_out_t m_data
);
    import kenv_pkg::*;

    // Hold the result transaction until taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    // One transaction in flight: input stalls right after an accept.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STAT_EVALUATED || m_data.status == STAT_APPENDED ||
                     m_data.status == STAT_DROPPED || m_data.status == STAT_EMPTY ||
                     m_data.status == STAT_CLEARED))
        else $error("undefined status code");

    // Only an evaluation carries value, stage and past-end.
    a_non_eval_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_EVALUATED |->
            m_data.result_value == '0 && m_data.active_stage == '0 && !m_data.past_end)
        else $error("non-evaluate result carries data");

    a_idle_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

endmodule

bind keyframe_envelope_interpolator kenv_checker u_kenv_checker (.*);

`default_nettype wire

[sim/kenv_checker.sv]
// Scoreboard for the keyframe envelope interpolator: watches both channels,
// predicts each result from its own copy of the stage table and compares.
// Depends on kenv_pkg for the payload structs and the request/status codes.
`timescale 1ns / 1ps

module kenv_scoreboard (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  kenv_pkg::kenv_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  kenv_pkg::kenv_out_t m_data,
    output int                  errors,
    output int                  pending,
    output int                  n_checked,
    output int                  n_interp,
    output int                  n_past,
    output int                  n_dropped
);
    import kenv_pkg::*;

    localparam int DEPTH      = MAX_STAGES_DEF;
    localparam int MAX_PRINTS = 40;

    logic [DUR_W-1:0]        dur_tbl [DEPTH];
    logic signed [VAL_W-1:0] val_tbl [DEPTH];
    int unsigned             n_stages;
    kenv_out_t               envelope_q[$];

    initial begin
        errors    = 0;
        pending   = 0;
        n_checked = 0;
        n_interp  = 0;
        n_past    = 0;
        n_dropped = 0;
        n_stages  = 0;
    end

    task automatic report_mismatch(input string what, input kenv_out_t got,
                                   input kenv_out_t want);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display({"[%0t] %s: got value=%0d stage=%0d status=%0d past=%0d,",
                      " want value=%0d stage=%0d status=%0d past=%0d"},
                     $time, what, got.result_value, got.active_stage, got.status,
                     got.past_end, want.result_value, want.active_stage, want.status,
                     want.past_end);
        end
    endtask

    // Apply one transaction to the stage table and return the result it causes.
    function automatic kenv_out_t envelope_step(input kenv_in_t item);
        kenv_out_t   res;
        int unsigned t, seg_start, seg_end, idx, num, dur, i;
        bit          hit;
        longint      frac, delta;
        res = '0;
        if (item.req_type == REQ_CLEAR) begin
            n_stages   = 0;
            res.status = STAT_CLEARED;
        end else if (item.req_type == REQ_APPEND) begin
            if (n_stages >= DEPTH) begin
                res.status = STAT_DROPPED;
                n_dropped++;
            end else begin
                dur_tbl[n_stages] = item.stage_duration_ms;
                val_tbl[n_stages] = item.stage_value;
                n_stages++;
                res.status = STAT_APPENDED;
            end
        end else if (n_stages == 0) begin
            // bit 1 of the request selects evaluation, so code 3 lands here too
            res.status = STAT_EMPTY;
        end else begin
            res.status = STAT_EVALUATED;
            t         = item.sim_time_ms;
            seg_start = 0;
            seg_end   = 0;
            idx       = 0;
            hit       = 1'b0;
            for (i = 0; i < n_stages && !hit; i++) begin
                seg_start = seg_end;
                seg_end   = seg_end + dur_tbl[i];
                if (t <= seg_end) begin
                    hit = 1'b1;
                    idx = i;
                end
            end
            if (!hit) begin
                idx              = n_stages - 1;
                res.past_end     = 1'b1;
                res.result_value = val_tbl[idx];
                n_past++;
            end else if (idx == 0) begin
                res.result_value = val_tbl[0];
            end else begin
                dur = dur_tbl[idx];
                num = (t > seg_start) ? t - seg_start : 0;
                if (num >= dur) begin
                    res.result_value = val_tbl[idx];
                end else begin
                    // Q0.16 fraction, then floor of the scaled step
                    frac  = (longint'(num) << 16) / longint'(dur);
                    delta = longint'(val_tbl[idx]) - longint'(val_tbl[idx-1]);
                    res.result_value = VAL_W'(longint'(val_tbl[idx-1]) + ((delta * frac) >>> 16));
                    n_interp++;
                end
            end
            res.active_stage = idx[STAGE_W-1:0];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        kenv_out_t want;
        if (!aresetn) begin
            n_stages = 0;
            envelope_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (envelope_q.size() == 0) begin
                    report_mismatch("result with nothing pending", m_data, '0);
                end else begin
                    want = envelope_q.pop_front();
                    n_checked++;
                    if (m_data.result_value !== want.result_value)
                        report_mismatch("result_value mismatch", m_data, want);
                    if (m_data.active_stage !== want.active_stage)
                        report_mismatch("active_stage mismatch", m_data, want);
                    if (m_data.status !== want.status)
                        report_mismatch("status mismatch", m_data, want);
                    if (m_data.past_end !== want.past_end)
                        report_mismatch("past_end mismatch", m_data, want);
                end
            end
            if (s_valid && s_ready)
                envelope_q.push_back(envelope_step(s_data));
        end
        pending = envelope_q.size();
    end

endmodule

[sim/tb_keyframe_envelope_interpolator.sv]
// Top of the keyframe envelope interpolator testbench: clock, reset, stimulus
// and verdict. Depends on kenv_pkg, the block itself and kenv_scoreboard.
`timescale 1ns / 1ps

module tb_keyframe_envelope_interpolator;
    import kenv_pkg::*;

    // Evaluation is selected by bit 1 of the request; code 3 is the alias.
    localparam logic [REQ_W-1:0] REQ_EVAL       = 2'd2;
    localparam logic [REQ_W-1:0] REQ_EVAL_ALIAS = 2'd3;

    localparam int N_ITEMS      = 650;
    localparam int CHOKE_AT     = 300;  // transaction count that triggers the hold-off
    localparam int CHOKE_CYCLES = 400;
    localparam int STEADY_FROM  = 450;  // stretch with no idling on either side
    localparam int STEADY_TO    = 520;
    localparam int DRAIN_CYCLES = 40;   // margin past the slowest evaluate

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    kenv_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    kenv_out_t m_data;

    int mismatches;
    int outstanding;
    int n_checked;
    int n_interp;
    int n_past;
    int n_dropped;

    int          n_sent;
    bit          steady;
    // Durations of the stages the block should currently hold; used to aim times.
    int unsigned plan_dur[$];

    keyframe_envelope_interpolator u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    kenv_scoreboard u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .errors    (mismatches),
        .pending   (outstanding),
        .n_checked (n_checked),
        .n_interp  (n_interp),
        .n_past    (n_past),
        .n_dropped (n_dropped)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs or a handshake never completes.
    initial begin
        #2_000_000;
        $display("keyframe_envelope_interpolator regression: fail");
        $finish;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    // Durations: mostly short so evaluations land inside the table, with the
    // zero-length and the longest stage mixed in.
    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 18) return '1;
        if (r < 33) return DUR_W'($urandom);
        return DUR_W'($urandom_range(1, 400));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return 16'h8000;
        if (r < 16) return 16'h7FFF;
        return VAL_W'($urandom);
    endfunction

    function automatic kenv_in_t mk(input logic [REQ_W-1:0] req,
                                    input logic [DUR_W-1:0] dur,
                                    input logic [VAL_W-1:0] val,
                                    input logic [TIME_W-1:0] t);
        kenv_in_t item;
        item.req_type          = req;
        item.stage_duration_ms = dur;
        item.stage_value       = val;
        item.sim_time_ms       = t;
        return item;
    endfunction

    // End time of stage j in the planned table.
    function automatic int unsigned stage_end(input int j);
        int unsigned acc;
        acc = 0;
        for (int k = 0; k <= j; k++) acc += plan_dur[k];
        return acc;
    endfunction

    // Offer one transaction after an idle gap, hold it until it is taken,
    // and track the table contents for aiming later evaluations.
    task automatic offer(input kenv_in_t item, input int gap);
        if (gap > 0 && !steady) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
        steady = (n_sent >= STEADY_FROM && n_sent < STEADY_TO);
        if (item.req_type == REQ_CLEAR)
            plan_dur.delete();
        else if (item.req_type == REQ_APPEND && plan_dur.size() < MAX_STAGES_DEF)
            plan_dur.push_back(item.stage_duration_ms);
    endtask

    // Pick an evaluation time: stage boundaries, zero, past the end, anywhere.
    task automatic offer_eval();
        int unsigned total, t;
        int          r;
        logic [REQ_W-1:0] req;
        total = (plan_dur.size() > 0) ? stage_end(plan_dur.size() - 1) : 0;
        r = $urandom_range(0, 99);
        if (r < 15 && plan_dur.size() > 0)
            t = stage_end($urandom_range(0, plan_dur.size() - 1)) + $urandom_range(0, 1);
        else if (r < 20)
            t = 0;
        else if (r < 30)
            t = $urandom_range(0, (1 << TIME_W) - 1);
        else if (r < 38)
            t = total + $urandom_range(1, 3);
        else
            t = $urandom_range(0, total);
        req = ($urandom_range(0, 9) == 0) ? REQ_EVAL_ALIAS : REQ_EVAL;
        offer(mk(req, DUR_W'($urandom), VAL_W'($urandom), TIME_W'(t)), pick_gap());
    endtask

    // Receiver: runs of ready with random stalls, one long hold-off that
    // backs the block up, and no stalls at all during the steady stretch.
    initial begin : rcv_ctrl
        int  run_len;
        int  stall_len;
        bit  choked;
        m_ready = 1'b0;
        choked  = 1'b0;
        @(posedge aclk);
        forever begin
            if (!choked && n_sent >= CHOKE_AT) begin
                choked = 1'b1;
                m_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge aclk);
            end
            run_len = $urandom_range(1, 24);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = steady ? 0 : pick_gap();
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    initial begin : stim
        int n_app;
        int n_eval;
        int i;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        n_sent  = 0;
        steady  = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, clear, fill to the brim with extreme stages,
        // one append too many, then times at boundaries and beyond the end.
        offer(mk(REQ_EVAL, '1, 16'h7FFF, '1), 0);
        offer(mk(REQ_CLEAR, '1, '1, '1), 0);
        offer(mk(REQ_APPEND, 16'd100,   16'h8000, '0), 0);
        offer(mk(REQ_APPEND, 16'd0,     16'h7FFF, '0), 0);   // zero-length stage
        offer(mk(REQ_APPEND, 16'hFFFF,  16'h8000, '0), 0);
        offer(mk(REQ_APPEND, 16'd1,     16'h7FFF, '0), 0);
        offer(mk(REQ_APPEND, 16'd1000,  16'h0100, '0), 0);
        offer(mk(REQ_APPEND, 16'd3,     16'hFFFF, '0), 0);
        offer(mk(REQ_APPEND, 16'hFFFF,  16'h7FFF, '0), 0);
        offer(mk(REQ_APPEND, 16'd7,     16'h8000, '0), 0);
        offer(mk(REQ_APPEND, '1, '1, '1), 0);                 // table full: dropped
        offer(mk(REQ_EVAL, '0, '0, 20'd0), 0);
        offer(mk(REQ_EVAL, '0, '0, 20'd100), 0);
        offer(mk(REQ_EVAL, '0, '0, 20'd101), 0);
        offer(mk(REQ_EVAL, '0, '0, 20'd65634), 0);           // fraction just below one
        offer(mk(REQ_EVAL, '0, '0, 20'd65636), 0);           // exact end of a stage
        offer(mk(REQ_EVAL, '0, '0, 20'd66000), 0);
        offer(mk(REQ_EVAL, '0, '0, 20'd132181), 0);          // exact end of the table
        offer(mk(REQ_EVAL, '0, '0, 20'd132182), 0);          // just past the end
        offer(mk(REQ_EVAL_ALIAS, '0, '0, '1), 0);            // alias code, latest time
        offer(mk(REQ_CLEAR, '0, '0, '0), 0);
        offer(mk(REQ_EVAL_ALIAS, '0, '0, 20'd5), 0);

        // Random: mostly clear / append / evaluate sequences with random
        // content, sometimes appending past the table size or onto an existing
        // table, plus loose random transactions of every request code.
        while (n_sent < N_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 99) < 85)
                    offer(mk(REQ_CLEAR, DUR_W'($urandom), VAL_W'($urandom),
                             TIME_W'($urandom)), pick_gap());
                n_app = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10)
                                                    : $urandom_range(1, 4);
                for (i = 0; i < n_app; i++)
                    offer(mk(REQ_APPEND, pick_duration(), pick_value(),
                             TIME_W'($urandom)), pick_gap());
                n_eval = $urandom_range(2, 8);
                for (i = 0; i < n_eval; i++)
                    offer_eval();
            end else begin
                offer(mk(REQ_W'($urandom_range(0, 3)), DUR_W'($urandom),
                         VAL_W'($urandom), TIME_W'($urandom)), pick_gap());
            end
        end
        s_valid <= 1'b0;
        // Let the scoreboard log the last accepted transaction before polling.
        @(posedge aclk);

        // Drain: every result in, then allow the block's latency for strays.
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d transactions, %0d results checked: %0d interpolated,",
                 n_sent, n_checked, n_interp);
        $display("%0d past the end, %0d appends dropped.", n_past, n_dropped);
        if (mismatches == 0 && outstanding == 0) begin
            $display("keyframe_envelope_interpolator regression: pass");
        end else begin
            $display("keyframe_envelope_interpolator regression: fail");
        end
        $finish;
    end

endmodule
